>>> rtl/dqne_pkg.sv
`timescale 1ns / 1ps
// dqne_pkg: request and result types, parser phase codes and framing constants
// for the dns question name extractor; depends on nothing
package dqne_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int FOOTER_BYTES = 4;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // header bytes that carry the question count, high byte first
    localparam logic [3:0] QCOUNT_HI_POS = 4'd4;
    localparam logic [3:0] QCOUNT_LO_POS = 4'd5;
    localparam logic [3:0] HEADER_LAST   = 4'(HEADER_BYTES - 1);
    localparam logic [1:0] FOOTER_LAST   = 2'(FOOTER_BYTES - 1);

    // parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_LABEL  = 3'd2;
    localparam logic [2:0] PH_FOOTER = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } dqne_req_t;

    typedef struct packed {
        logic [7:0]  name_char;
        logic [15:0] question_index;
        logic        name_end;
    } dqne_res_t;

endpackage

>>> rtl/dqne_in_stage.sv
`timescale 1ns / 1ps
// dqne_in_stage: input register for requests with valid/stall handshake
// depends on dqne_pkg
module dqne_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  dqne_pkg::dqne_req_t item,
    input  logic                take,
    output logic                held_valid,
    output dqne_pkg::dqne_req_t held_item
);
    import dqne_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    dqne_req_t data_reg;
    logic      load;

    // slot frees up when the held request is taken this cycle
    assign item_stall = valid_reg && !take;
    assign load       = item_valid && !item_stall;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = data_reg;

endmodule

>>> rtl/dqne_parser.sv
`timescale 1ns / 1ps
// dqne_parser: question name parser state and per-byte next-state/result logic
// depends on dqne_pkg
module dqne_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  dqne_pkg::dqne_req_t req,
    output logic                res_valid,
    output dqne_pkg::dqne_res_t res
);
    import dqne_pkg::*;

    logic [2:0]  phase_reg,  phase_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [15:0] q_total_reg, q_total_next;
    logic [15:0] q_done_reg, q_done_next;
    logic [7:0]  label_left_reg, label_left_next;
    logic        first_label_reg, first_label_next;
    logic [1:0]  ftr_cnt_reg, ftr_cnt_next;

    // state as seen by this byte (packet start restarts from reset values)
    logic [2:0]  ph;
    logic [3:0]  hc;
    logic [15:0] qt;
    logic [15:0] qd;
    logic [7:0]  ll;
    logic        fl;
    logic [1:0]  fc;
    logic [15:0] qd_inc;
    logic [7:0]  b;

    always_comb
    begin
        b  = req.data_byte;
        ph = req.packet_start ? PH_HEADER : phase_reg;
        hc = req.packet_start ? 4'd0 : hdr_cnt_reg;
        qt = req.packet_start ? 16'd0 : q_total_reg;
        qd = req.packet_start ? 16'd0 : q_done_reg;
        ll = req.packet_start ? 8'd0 : label_left_reg;
        fl = req.packet_start ? 1'b1 : first_label_reg;
        fc = req.packet_start ? 2'd0 : ftr_cnt_reg;
        qd_inc = qd + 16'd1;

        phase_next       = ph;
        hdr_cnt_next     = hc;
        q_total_next     = qt;
        q_done_next      = qd;
        label_left_next  = ll;
        first_label_next = fl;
        ftr_cnt_next     = fc;

        res_valid          = 1'b0;
        res.name_char      = b;
        res.question_index = qd;
        res.name_end       = 1'b0;

        case (ph)
            PH_HEADER:
            begin
                if (hc == QCOUNT_HI_POS)
                begin
                    q_total_next = {b, qt[7:0]};
                end
                else if (hc == QCOUNT_LO_POS)
                begin
                    q_total_next = {qt[15:8], b};
                end
                if (hc == HEADER_LAST)
                begin
                    hdr_cnt_next     = 4'd0;
                    first_label_next = 1'b1;
                    phase_next       = (q_total_next == 16'd0) ? PH_DONE : PH_LENGTH;
                end
                else
                begin
                    hdr_cnt_next = hc + 4'd1;
                end
            end
            PH_LENGTH:
            begin
                if (b == 8'd0)
                begin
                    res_valid        = 1'b1;
                    res.name_char    = 8'd0;
                    res.name_end     = 1'b1;
                    first_label_next = 1'b1;
                    ftr_cnt_next     = 2'd0;
                    phase_next       = PH_FOOTER;
                end
                else
                begin
                    label_left_next  = b;
                    phase_next       = PH_LABEL;
                    first_label_next = 1'b0;
                    if (!fl)
                    begin
                        res_valid     = 1'b1;
                        res.name_char = DOT_CHAR;
                    end
                end
            end
            PH_LABEL:
            begin
                res_valid       = 1'b1;
                label_left_next = ll - 8'd1;
                if (ll == 8'd1)
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_FOOTER:
            begin
                if (fc == FOOTER_LAST)
                begin
                    ftr_cnt_next = 2'd0;
                    q_done_next  = qd_inc;
                    phase_next   = (qd_inc == qt) ? PH_DONE : PH_LENGTH;
                end
                else
                begin
                    ftr_cnt_next = fc + 2'd1;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            hdr_cnt_reg     <= 4'd0;
            q_total_reg     <= 16'd0;
            q_done_reg      <= 16'd0;
            label_left_reg  <= 8'd0;
            first_label_reg <= 1'b1;
            ftr_cnt_reg     <= 2'd0;
        end
        else if (take)
        begin
            phase_reg       <= phase_next;
            hdr_cnt_reg     <= hdr_cnt_next;
            q_total_reg     <= q_total_next;
            q_done_reg      <= q_done_next;
            label_left_reg  <= label_left_next;
            first_label_reg <= first_label_next;
            ftr_cnt_reg     <= ftr_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_hdr_cnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg != 4'd0 |-> phase_reg == PH_HEADER)
        else $error("header count running outside header phase");

    a_ftr_cnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ftr_cnt_reg != 2'd0 |-> phase_reg == PH_FOOTER)
        else $error("footer count running outside footer phase");

    a_label_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LABEL |-> label_left_reg != 8'd0)
        else $error("label phase with no label bytes left");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && req.packet_start |=> phase_reg == PH_HEADER && hdr_cnt_reg == 4'd1)
        else $error("packet start did not restart the header");
`endif

endmodule

>>> rtl/dns_question_name_extractor.sv
`timescale 1ns / 1ps
// dns_question_name_extractor: top level, input register, parser and result register
// depends on dqne_pkg, dqne_in_stage, dqne_parser
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------
//  request  | item_valid / item_stall     | item      (data_byte, packet_start)
//  result   | name_valid / name_stall     | name_item (name_char, question_index,
//           |                             |            name_end)
//
// one request per cycle sustained while name_stall is low; a request is registered
// in the input register, parsed by the combinational next-state logic, and its
// result, if any, goes to the result register; bytes after the last question give none
// requests that produce no result (header, first length, footer bytes) only advance state
// reset clears the valid bits and puts the parser in the header phase
// a stalled result holds the parser; the input register still takes one more
// request, after which item_stall rises
module dns_question_name_extractor (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  dqne_pkg::dqne_req_t item,
    output logic                name_valid,
    input  logic                name_stall,
    output dqne_pkg::dqne_res_t name_item
);
    import dqne_pkg::*;

    logic      held_valid;
    dqne_req_t held_item;
    logic      take;
    logic      res_valid;
    dqne_res_t res;

    logic      out_valid_reg;
    logic      out_valid_next;
    dqne_res_t out_data_reg;
    logic      out_free;

    // result register can take a new value when empty or being drained
    assign out_free = !out_valid_reg || !name_stall;
    // parser consumes the held request whenever the result side has room
    assign take     = held_valid && out_free;

    dqne_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    dqne_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .req       (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register: reload when free, otherwise hold the stalled result
    always_comb
    begin
        if (out_free)
        begin
            out_valid_next = take && res_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign name_valid = out_valid_reg;
    assign name_item  = out_data_reg;

endmodule

>>> tb/dqne_name_checker.sv
`timescale 1ns / 1ps
// dqne_name_checker: watches both channels of the dns question name extractor,
// predicts the dotted name characters and compares them in order
// depends on dqne_pkg
module dqne_name_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  dqne_pkg::dqne_req_t item,
    input  logic                name_valid,
    input  logic                name_stall,
    input  dqne_pkg::dqne_res_t name_item,
    output int                  mismatches,
    output int                  outstanding
);
    import dqne_pkg::*;

    // predicted parser state
    logic [2:0]  phase;
    logic [3:0]  hdr_pos;
    logic [15:0] q_total;
    logic [15:0] q_done;
    logic [7:0]  label_left;
    logic        first_label;
    logic [1:0]  ftr_pos;

    dqne_res_t expected_names[$];
    dqne_res_t want;

    initial mismatches = 0;

    task automatic clear_parser();
        phase       = PH_HEADER;
        hdr_pos     = '0;
        q_total     = '0;
        q_done      = '0;
        label_left  = '0;
        first_label = 1'b1;
        ftr_pos     = '0;
    endtask

    task automatic add_name_char(input logic [7:0] ch, input logic last);
        dqne_res_t r;
        r.name_char      = ch;
        r.question_index = q_done;
        r.name_end       = last;
        expected_names.push_back(r);
    endtask

    task automatic parse_request(input dqne_req_t req);
        if (req.packet_start)
            clear_parser();
        case (phase)
            PH_HEADER:
            begin
                if (hdr_pos == QCOUNT_HI_POS)
                    q_total[15:8] = req.data_byte;
                else if (hdr_pos == QCOUNT_LO_POS)
                    q_total[7:0] = req.data_byte;
                if (hdr_pos == HEADER_LAST)
                begin
                    hdr_pos     = '0;
                    first_label = 1'b1;
                    phase       = (q_total == 16'd0) ? PH_DONE : PH_LENGTH;
                end
                else
                begin
                    hdr_pos = hdr_pos + 4'd1;
                end
            end
            PH_LENGTH:
            begin
                if (req.data_byte == 8'd0)
                begin
                    add_name_char(8'd0, 1'b1);
                    first_label = 1'b1;
                    ftr_pos     = '0;
                    phase       = PH_FOOTER;
                end
                else
                begin
                    label_left = req.data_byte;
                    phase      = PH_LABEL;
                    if (!first_label)
                        add_name_char(DOT_CHAR, 1'b0);
                    first_label = 1'b0;
                end
            end
            PH_LABEL:
            begin
                add_name_char(req.data_byte, 1'b0);
                label_left = label_left - 8'd1;
                if (label_left == 8'd0)
                    phase = PH_LENGTH;
            end
            PH_FOOTER:
            begin
                if (ftr_pos == FOOTER_LAST)
                begin
                    ftr_pos = '0;
                    q_done  = q_done + 16'd1;
                    phase   = (q_done == q_total) ? PH_DONE : PH_LENGTH;
                end
                else
                begin
                    ftr_pos = ftr_pos + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_names.delete();
        end
        else
        begin
            // results first: a request never yields a result in its own cycle
            if (name_valid && !name_stall)
            begin
                if (expected_names.size() == 0)
                begin
                    $error("unexpected result: name_char %0h question_index %0d name_end %0b",
                           name_item.name_char, name_item.question_index, name_item.name_end);
                    mismatches++;
                end
                else
                begin
                    want = expected_names.pop_front();
                    if (name_item.name_char !== want.name_char)
                    begin
                        $error("name_char expected %0h actual %0h",
                               want.name_char, name_item.name_char);
                        mismatches++;
                    end
                    if (name_item.question_index !== want.question_index)
                    begin
                        $error("question_index expected %0d actual %0d",
                               want.question_index, name_item.question_index);
                        mismatches++;
                    end
                    if (name_item.name_end !== want.name_end)
                    begin
                        $error("name_end expected %0b actual %0b",
                               want.name_end, name_item.name_end);
                        mismatches++;
                    end
                end
            end
            if (item_valid && !item_stall)
                parse_request(item);
        end
        outstanding = expected_names.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for the dns question name extractor
// depends on dqne_pkg, dns_question_name_extractor and dqne_name_checker
module tb;
    import dqne_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 750;
    // the last stretch of random packets runs with no gaps and no stalls
    localparam int QUIET_TAIL   = 120;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      item_valid = 1'b0;
    dqne_req_t item       = '0;
    logic      name_stall = 1'b0;
    logic      item_stall;
    logic      name_valid;
    dqne_res_t name_item;

    int   mismatches;
    int   outstanding;
    int   cycles = 0;
    // random gaps on the request side and stalls on the result side
    logic jitter = 1'b0;

    // bytes of the packet about to be sent
    dqne_req_t packet_bytes[$];

    dns_question_name_extractor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .name_valid (name_valid),
        .name_stall (name_stall),
        .name_item  (name_item)
    );

    dqne_name_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .name_valid  (name_valid),
        .name_stall  (name_stall),
        .name_item   (name_item),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog: covers a hung handshake and results that never show up
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[dns_question_name_extractor] ERROR");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (jitter && $urandom_range(0, 5) == 0)
            begin
                name_stall = 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                name_stall = 1'b0;
            end
        end
    end

    // present one request at the falling edge and hold it until it is taken
    task automatic send_request(input dqne_req_t req);
        @(negedge clk);
        if (jitter && $urandom_range(0, 6) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        item_valid = 1'b1;
        item       = req;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // stop sending until every predicted character has come out
    task automatic drain_names();
        @(negedge clk);
        item_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic start);
        packet_bytes.push_back({b, start});
    endtask

    // label lengths: mostly short, sometimes long, and now and then
    // lengths of 192 and up, which must be read as plain lengths
    function automatic logic [7:0] pick_label_len();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0)
            return 8'($urandom_range(192, 255));
        else if (r == 1)
            return 8'($urandom_range(64, 191));
        else if (r <= 4)
            return 8'($urandom_range(7, 63));
        return 8'($urandom_range(1, 6));
    endfunction

    // one packet: header with question count, questions made of labels,
    // terminator and footer, a few bytes past the end; sometimes cut short,
    // sometimes plain noise that does not count toward the total
    task automatic build_packet(output int parsed);
        logic [15:0] q_count;
        logic [7:0]  len;
        int          r;
        int          shown;
        int          cut;
        packet_bytes.delete();
        parsed = 0;
        if ($urandom_range(0, 11) == 0)
        begin
            repeat ($urandom_range(1, 16))
                add_byte(8'($urandom), $urandom_range(0, 15) == 0);
            return;
        end
        r = $urandom_range(0, 19);
        if (r == 0)
            q_count = 16'd0;
        else if (r == 1)
            q_count = 16'($urandom);
        else
            q_count = 16'($urandom_range(1, 3));
        // a missing packet start on byte 0 is a broken sequence on purpose
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            if (i == QCOUNT_HI_POS)
                add_byte(q_count[15:8], 1'b0);
            else if (i == QCOUNT_LO_POS)
                add_byte(q_count[7:0], 1'b0);
            else
                add_byte(8'($urandom), i == 0 && $urandom_range(0, 15) != 0);
        end
        shown = (q_count > 16'd4) ? $urandom_range(1, 3) : int'(q_count);
        for (int q = 0; q < shown; q++)
        begin
            // zero labels gives the empty root name
            repeat ($urandom_range(0, 3))
            begin
                len = pick_label_len();
                add_byte(len, 1'b0);
                repeat (len)
                    add_byte(8'($urandom), 1'b0);
            end
            add_byte(8'd0, 1'b0);
            repeat (FOOTER_BYTES)
                add_byte(8'($urandom), 1'b0);
        end
        repeat ($urandom_range(0, 3))
            add_byte(8'($urandom), 1'b0);
        // truncated packet: the next packet start lands in mid-parse
        if ($urandom_range(0, 7) == 0)
        begin
            cut = $urandom_range(1, packet_bytes.size());
            while (packet_bytes.size() > cut)
                void'(packet_bytes.pop_back());
        end
        parsed = packet_bytes.size();
    endtask

    initial
    begin
        logic [7:0] first_names [13];
        int sent;
        int parsed;

        first_names = '{
            8'd2, 8'h00, 8'hFF, 8'd1, 8'h41, 8'd0,   // name with zero and 0xff in a label
            8'hFF, 8'hFF, 8'h00, 8'h00,              // footer
            8'd0,                                    // second question: empty root name
            8'h12, 8'h34                             // footer cut short
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: bytes right after reset with no packet start, question
        // count of two, zero byte inside a label, empty root name, then the
        // packet stops in the footer and the first random packet restarts it
        packet_bytes.delete();
        for (int i = 0; i < HEADER_BYTES; i++)
            add_byte((i == QCOUNT_LO_POS) ? 8'd2 : (i[0] ? 8'hFF : 8'h00), 1'b0);
        foreach (first_names[i])
            add_byte(first_names[i], 1'b0);
        foreach (packet_bytes[i])
            send_request(packet_bytes[i]);
        drain_names();

        // random packets, mostly well formed with random content
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            build_packet(parsed);
            jitter = (sent < RANDOM_BYTES - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            foreach (packet_bytes[i])
                send_request(packet_bytes[i]);
            sent += parsed;
            if ($urandom_range(0, 29) == 0)
                drain_names();
        end
        jitter = 1'b0;

        @(negedge clk);
        item_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        // catch any stray result past the two-stage pipeline
        repeat (10) @(negedge clk);

        if (mismatches == 0)
            $display("[dns_question_name_extractor] OK");
        else
            $display("[dns_question_name_extractor] ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/dqne_pkg.sv
rtl/dqne_in_stage.sv
rtl/dqne_parser.sv
rtl/dns_question_name_extractor.sv
tb/dqne_name_checker.sv
tb/tb.sv
